[rtl/core/mpconv_pkg.sv]
// Shared types and codes for the min-plus convolution block.
`default_nettype none

package mpconv_pkg;

   typedef enum logic [1:0] {
      ACT_APPEND_FIRST  = 2'd0,
      ACT_APPEND_SECOND = 2'd1,
      ACT_COMPUTE       = 2'd2,
      ACT_NONE          = 2'd3
   } action_type;

   typedef enum logic [1:0] {
      STAT_OK        = 2'd0,
      STAT_EMPTY     = 2'd1,
      STAT_NOT_CONV  = 2'd2,
      STAT_TOO_LONG  = 2'd3
   } status_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_START,
      ST_READ,
      ST_ACC,
      ST_EMIT
   } state_type;

   typedef struct packed {
      action_type         action;
      logic signed [31:0] value;
   } req_type;

   typedef struct packed {
      logic signed [32:0] sum_min;
      status_type         status;
      logic               last;
   } rsp_type;

endpackage

`default_nettype wire

[rtl/core/mpconv_seq.sv]
// One sequence store: element memory, fill count and running convexity check.
`default_nettype none

module mpconv_seq #(
   parameter int MAX_LEN = 32,
   localparam int AW = $clog2(MAX_LEN),
   localparam int CW = $clog2(MAX_LEN + 1)
) (
   input  wire logic                clock,
   input  wire logic                reset,
   input  wire logic                clear,
   input  wire logic                append,
   input  wire logic signed [31:0]  value,
   input  wire logic [AW-1:0]       rd_addr,
   output logic [CW-1:0]            count,
   output logic                     convex,
   output logic signed [31:0]       rd_data
);
   import mpconv_pkg::*;

   logic signed [31:0] mem [MAX_LEN];
   logic [CW-1:0]      count_ff, count_in;
   logic               convex_ff, convex_in;
   logic signed [31:0] prev_ff, prev_in;
   logic signed [31:0] last_ff, last_in;
   logic signed [31:0] rd_data_ff;
   logic               full;
   logic               wr;
   logic signed [34:0] diff2;

   assign full = (count_ff == CW'(MAX_LEN));
   assign wr   = append && !full;

   // second difference of the two held elements and the incoming one
   assign diff2 = 35'(prev_ff) - (35'(last_ff) <<< 1) + 35'(value);

   always_comb begin
      count_in  = count_ff;
      convex_in = convex_ff;
      prev_in   = prev_ff;
      last_in   = last_ff;
      if (clear) begin
         count_in  = '0;
         convex_in = 1'b1;
      end else if (wr) begin
         count_in = count_ff + CW'(1);
         prev_in  = last_ff;
         last_in  = value;
         if (count_ff >= CW'(2) && diff2 < 0) begin
            convex_in = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff  <= '0;
         convex_ff <= 1'b1;
      end else begin
         count_ff  <= count_in;
         convex_ff <= convex_in;
      end
      prev_ff <= prev_in;
      last_ff <= last_in;
   end

   always_ff @(posedge clock) begin
      if (wr) begin
         mem[count_ff[AW-1:0]] <= value;
      end
      rd_data_ff <= mem[rd_addr];
   end

   assign count   = count_ff;
   assign convex  = convex_ff;
   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

[rtl/core/min_plus_convolution_convex.sv]
// Min-plus convolution: loads two sequences, then walks each output over one shared adder.
// Append items: one per cycle, no result. Compute: each output i runs a setup state, then per term
//   a memory read and then an add and min, then an emit state; an error result goes from the
//   compute item straight to emit. The input is stalled until the last result loads.
// Output register holds a result while the consumer stalls.
// Synchronous reset clears both fill counts and the sequencer; stores hold no reset value.
`default_nettype none

module min_plus_convolution_convex #(
   parameter int MAX_LEN = 32
) (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              req_valid,
   output logic                   req_stall,
   input  wire mpconv_pkg::req_type req_data,
   output logic                   rsp_valid,
   input  wire logic              rsp_stall,
   output mpconv_pkg::rsp_type    rsp_data
);
   import mpconv_pkg::*;

   localparam int AW = $clog2(MAX_LEN);
   localparam int CW = $clog2(MAX_LEN + 1);
   localparam int IW = $clog2(2 * MAX_LEN);

   state_type          state_ff, state_in;
   logic [CW-1:0]      pn_ff, pn_in, qn_ff, qn_in;
   logic               swap_ff, swap_in;
   status_type         stat_ff, stat_in;
   logic [IW-1:0]      i_ff, i_in;
   logic [AW-1:0]      j_ff, j_in, lo_ff, lo_in, hi_ff, hi_in;
   logic signed [32:0] best_ff, best_in;
   logic               rsp_valid_ff, rsp_valid_in;
   rsp_type            rsp_ff, rsp_in;

   logic               accept;
   logic               out_free;
   logic               clear;
   logic               app_first, app_second;
   logic [CW-1:0]      first_count, second_count;
   logic               first_convex, second_convex;
   logic signed [31:0] first_rd, second_rd;
   logic [AW-1:0]      first_addr, second_addr, q_addr;
   logic signed [31:0] p_val, q_val;
   logic signed [32:0] term;
   logic [IW:0]        i_ext, lo_calc, final_i;
   logic               is_last;

   assign accept   = req_valid && !req_stall;
   assign out_free = !rsp_valid_ff || !rsp_stall;
   assign req_stall = (state_ff != ST_IDLE);

   assign app_first  = accept && (req_data.action == ACT_APPEND_FIRST);
   assign app_second = accept && (req_data.action == ACT_APPEND_SECOND);
   assign clear      = accept && (req_data.action == ACT_COMPUTE);

   // q is the convex side; swap means q lives in the first store
   assign q_addr      = AW'(i_ff - IW'(j_ff));
   assign first_addr  = swap_ff ? q_addr : j_ff;
   assign second_addr = swap_ff ? j_ff : q_addr;
   assign p_val       = swap_ff ? second_rd : first_rd;
   assign q_val       = swap_ff ? first_rd : second_rd;
   assign term        = 33'(p_val) + 33'(q_val);

   assign i_ext   = (IW + 1)'(i_ff);
   assign lo_calc = (i_ext + (IW + 1)'(1) > (IW + 1)'(qn_ff))
                    ? i_ext + (IW + 1)'(1) - (IW + 1)'(qn_ff) : '0;
   assign final_i = (IW + 1)'(pn_ff) + (IW + 1)'(qn_ff) - (IW + 1)'(2);
   assign is_last = (i_ext == final_i);

   mpconv_seq #(.MAX_LEN(MAX_LEN)) u_first (
      .clock   (clock),
      .reset   (reset),
      .clear   (clear),
      .append  (app_first),
      .value   (req_data.value),
      .rd_addr (first_addr),
      .count   (first_count),
      .convex  (first_convex),
      .rd_data (first_rd)
   );

   mpconv_seq #(.MAX_LEN(MAX_LEN)) u_second (
      .clock   (clock),
      .reset   (reset),
      .clear   (clear),
      .append  (app_second),
      .value   (req_data.value),
      .rd_addr (second_addr),
      .count   (second_count),
      .convex  (second_convex),
      .rd_data (second_rd)
   );

   always_comb begin
      state_in     = state_ff;
      pn_in        = pn_ff;
      qn_in        = qn_ff;
      swap_in      = swap_ff;
      stat_in      = stat_ff;
      i_in         = i_ff;
      j_in         = j_ff;
      lo_in        = lo_ff;
      hi_in        = hi_ff;
      best_in      = best_ff;
      rsp_in       = rsp_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;

      case (state_ff)
         ST_IDLE: begin
            if (clear) begin
               swap_in = !second_convex;
               pn_in   = second_convex ? first_count : second_count;
               qn_in   = second_convex ? second_count : first_count;
               i_in    = '0;
               if (first_count == '0 || second_count == '0) begin
                  stat_in  = STAT_EMPTY;
                  state_in = ST_EMIT;
               end else if (!first_convex && !second_convex) begin
                  stat_in  = STAT_NOT_CONV;
                  state_in = ST_EMIT;
               end else if ((second_convex ? second_count : first_count) >
                            (second_convex ? first_count : second_count)) begin
                  stat_in  = STAT_TOO_LONG;
                  state_in = ST_EMIT;
               end else begin
                  stat_in  = STAT_OK;
                  state_in = ST_START;
               end
            end
         end
         ST_START: begin
            lo_in = AW'(lo_calc);
            hi_in = (i_ext < (IW + 1)'(pn_ff) - (IW + 1)'(1))
                    ? AW'(i_ff) : AW'(pn_ff - CW'(1));
            j_in     = AW'(lo_calc);
            state_in = ST_READ;
         end
         ST_READ: begin
            state_in = ST_ACC;
         end
         ST_ACC: begin
            if (j_ff == lo_ff || term < best_ff) begin
               best_in = term;
            end
            if (j_ff == hi_ff) begin
               state_in = ST_EMIT;
            end else begin
               j_in     = j_ff + AW'(1);
               state_in = ST_READ;
            end
         end
         ST_EMIT: begin
            if (out_free) begin
               rsp_valid_in   = 1'b1;
               rsp_in.status  = stat_ff;
               if (stat_ff == STAT_OK) begin
                  rsp_in.sum_min = best_ff;
                  rsp_in.last    = is_last;
                  if (is_last) begin
                     state_in = ST_IDLE;
                  end else begin
                     i_in     = i_ff + IW'(1);
                     state_in = ST_START;
                  end
               end else begin
                  rsp_in.sum_min = '0;
                  rsp_in.last    = 1'b1;
                  state_in       = ST_IDLE;
               end
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      pn_ff   <= pn_in;
      qn_ff   <= qn_in;
      swap_ff <= swap_in;
      stat_ff <= stat_in;
      i_ff    <= i_in;
      j_ff    <= j_in;
      lo_ff   <= lo_in;
      hi_ff   <= hi_in;
      best_ff <= best_in;
      rsp_ff  <= rsp_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

endmodule

`default_nettype wire

[tb/sv/tb_top.sv]
// Self-checking testbench for the min-plus convolution block: directed cases, then random runs.
module tb_top;
   import mpconv_pkg::*;

   typedef logic signed [31:0] seq_type[$];

   localparam int MAX_LEN = 32;
   localparam int CYCLE_LIMIT = 1_000_000;
   localparam logic signed [31:0] WORD_MIN = 32'sh8000_0000;
   localparam logic signed [31:0] WORD_MAX = 32'sh7fff_ffff;

   logic    clock;
   logic    reset;
   logic    req_valid;
   logic    req_stall;
   req_type req_data;
   logic    rsp_valid;
   logic    rsp_stall;
   rsp_type rsp_data;

   // predictor state
   seq_type first_seq;
   seq_type second_seq;
   rsp_type pending_results[$];

   int fail_count = 0;
   int items_sent = 0;
   int cycle_count = 0;
   bit req_idle_on = 1'b1;
   bit rsp_idle_on = 1'b1;

   min_plus_convolution_convex #(.MAX_LEN(MAX_LEN)) uut (
      .clock(clock),
      .reset(reset),
      .req_valid(req_valid),
      .req_stall(req_stall),
      .req_data(req_data),
      .rsp_valid(rsp_valid),
      .rsp_stall(rsp_stall),
      .rsp_data(rsp_data)
   );

   initial clock = 1'b0;
   always #2 clock = ~clock;

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("tb: failure");
         $finish;
      end
   end

   function automatic bit check_convex(seq_type s);
      longint d;
      for (int k = 1; k + 1 < s.size(); k++) begin
         d = longint'(s[k-1]) - 2 * longint'(s[k]) + longint'(s[k+1]);
         if (d < 0) return 1'b0;
      end
      return 1'b1;
   endfunction

   function automatic void push_flag(status_type st);
      rsp_type r;
      r.sum_min = '0;
      r.status = st;
      r.last = 1'b1;
      pending_results.insert(pending_results.size(), r);
   endfunction

   function automatic void convolve_stores();
      seq_type p, q;
      int      pn, qn, rs, lo, hi;
      longint  best, sum;
      bit      fc, sc;
      rsp_type r;
      if (first_seq.size() == 0 || second_seq.size() == 0) begin
         push_flag(STAT_EMPTY);
         return;
      end
      fc = check_convex(first_seq);
      sc = check_convex(second_seq);
      if (!fc && !sc) begin
         push_flag(STAT_NOT_CONV);
         return;
      end
      // the convex operand goes to q; second keeps that role when both are convex
      if (sc) begin
         p = first_seq;
         q = second_seq;
      end else begin
         p = second_seq;
         q = first_seq;
      end
      pn = p.size();
      qn = q.size();
      if (qn > pn) begin
         push_flag(STAT_TOO_LONG);
         return;
      end
      rs = pn + qn - 1;
      for (int i = 0; i < rs; i++) begin
         lo = (i + 1 > qn) ? i + 1 - qn : 0;
         hi = (i < pn - 1) ? i : pn - 1;
         best = longint'(p[lo]) + longint'(q[i-lo]);
         for (int j = lo + 1; j <= hi; j++) begin
            sum = longint'(p[j]) + longint'(q[i-j]);
            if (sum < best) best = sum;
         end
         r.sum_min = best[32:0];
         r.status = STAT_OK;
         r.last = (i == rs - 1);
         pending_results.insert(pending_results.size(), r);
      end
   endfunction

   function automatic void absorb_item(action_type act, logic signed [31:0] val);
      case (act)
         ACT_APPEND_FIRST: begin
            if (first_seq.size() < MAX_LEN) first_seq.insert(first_seq.size(), val);
         end
         ACT_APPEND_SECOND: begin
            if (second_seq.size() < MAX_LEN) second_seq.insert(second_seq.size(), val);
         end
         ACT_COMPUTE: begin
            convolve_stores();
            first_seq.delete();
            second_seq.delete();
         end
         default: ;
      endcase
   endfunction

   // a + b*(k-m) + c*(k-m)^2 with c >= 0, shrunk until every term fits 32 bits
   function automatic seq_type make_convex(int n);
      seq_type s;
      longint  a, b, c, v, dk;
      int      m, shift;
      bit      fits;
      shift = $urandom_range(0, 20);
      m = $urandom_range(0, n - 1);
      forever begin
         a = longint'($signed($urandom)) >>> shift;
         b = longint'($signed($urandom)) >>> (shift + 6);
         c = longint'($urandom) >> (shift + 11);
         s.delete();
         fits = 1'b1;
         for (int k = 0; k < n; k++) begin
            dk = longint'(k - m);
            v = a + b * dk + c * dk * dk;
            if (v > 64'sd2147483647 || v < -64'sd2147483648) fits = 1'b0;
            s.insert(s.size(), v[31:0]);
         end
         if (fits) break;
         shift++;
      end
      return s;
   endfunction

   function automatic seq_type make_random(int n);
      seq_type s;
      for (int k = 0; k < n; k++) s.insert(s.size(), $urandom);
      return s;
   endfunction

   function automatic seq_type make_bumpy(int n);
      seq_type s;
      s = make_random(n);
      if (check_convex(s)) begin
         s[0] = '0;
         s[1] = WORD_MAX;
         s[2] = '0;
      end
      return s;
   endfunction

   task automatic send_item(action_type act, logic signed [31:0] val);
      int gap;
      gap = req_idle_on ? $urandom_range(0, 7) : 0;
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_data <= '{action: act, value: val};
      @(posedge clock);
      while (req_stall) @(posedge clock);
      if (act != ACT_NONE) items_sent++;
      absorb_item(act, val);
   endtask

   // appends both sequences in random interleave, then the compute item
   task automatic send_run(seq_type f, seq_type s, bit noisy);
      int i, j;
      i = 0;
      j = 0;
      while (i < f.size() || j < s.size()) begin
         if (noisy && $urandom_range(0, 19) == 0) send_item(ACT_NONE, $urandom);
         if (j >= s.size() || (i < f.size() && $urandom_range(0, 1) == 1)) begin
            send_item(ACT_APPEND_FIRST, f[i]);
            i++;
         end else begin
            send_item(ACT_APPEND_SECOND, s[j]);
            j++;
         end
      end
      send_item(ACT_COMPUTE, $urandom);
   endtask

   task automatic test_empty_compute();
      send_item(ACT_COMPUTE, $urandom);
   endtask

   task automatic test_value_extremes();
      seq_type f, s;
      f = {WORD_MIN, WORD_MAX};
      s = {WORD_MIN, WORD_MAX};
      send_item(ACT_NONE, $urandom);
      send_run(f, s, 1'b0);
   endtask

   task automatic test_neither_convex();
      seq_type f, s;
      f = {32'sd0, WORD_MAX, 32'sd0};
      s = {-32'sd5, 32'sd3, -32'sd5};
      send_run(f, s, 1'b0);
   endtask

   task automatic test_convex_too_long();
      seq_type f, s;
      f = {32'sd1};
      s = {32'sd1, 32'sd2};
      send_run(f, s, 1'b0);
   endtask

   task automatic test_swapped_operands();
      seq_type f, s;
      f = {32'sd1, 32'sd0, 32'sd2};
      s = {32'sd0, 32'sd9, 32'sd0};
      send_run(f, s, 1'b0);
   endtask

   task automatic test_random_runs(int target);
      seq_type f, s;
      int      kind, nmax, fn, sn, start;
      start = items_sent;
      while (items_sent - start < target) begin
         req_idle_on = ($urandom_range(0, 3) != 0);
         rsp_idle_on = ($urandom_range(0, 3) != 0);
         nmax = ($urandom_range(0, 14) == 0) ? MAX_LEN : 8;
         kind = $urandom_range(0, 99);
         if (kind < 50) begin
            // well-formed: second convex and no longer than first
            sn = $urandom_range(1, nmax);
            fn = $urandom_range(sn, nmax);
            s = make_convex(sn);
            f = $urandom_range(0, 1) ? make_convex(fn) : make_random(fn);
         end else if (kind < 65) begin
            // only first convex, so the operands swap
            fn = $urandom_range(1, nmax);
            sn = $urandom_range((fn < 3) ? 3 : fn, nmax);
            f = make_convex(fn);
            s = make_bumpy(sn);
         end else if (kind < 73) begin
            if ($urandom_range(0, 1)) begin
               sn = $urandom_range(2, nmax);
               fn = $urandom_range(1, sn - 1);
               s = make_convex(sn);
               f = $urandom_range(0, 1) ? make_convex(fn) : make_random(fn);
            end else begin
               fn = $urandom_range(4, nmax);
               sn = $urandom_range(3, fn - 1);
               f = make_convex(fn);
               s = make_bumpy(sn);
            end
         end else if (kind < 80) begin
            f = make_bumpy($urandom_range(3, nmax));
            s = make_bumpy($urandom_range(3, nmax));
         end else if (kind < 87) begin
            fn = $urandom_range(0, 1) ? 0 : $urandom_range(1, nmax);
            sn = (fn == 0) ? $urandom_range(0, nmax) : 0;
            f = make_random(fn);
            s = make_random(sn);
         end else if (kind < 93) begin
            // overfill one store; appends past capacity are dropped
            if ($urandom_range(0, 1)) begin
               f = make_convex($urandom_range(MAX_LEN + 1, MAX_LEN + 4));
               s = make_convex($urandom_range(1, 8));
            end else begin
               s = make_convex($urandom_range(MAX_LEN + 1, MAX_LEN + 4));
               f = make_random($urandom_range(1, MAX_LEN));
            end
         end else begin
            f = make_random($urandom_range(0, nmax));
            s = make_random($urandom_range(0, nmax));
         end
         send_run(f, s, 1'b1);
      end
   endtask

   // result side: random stall per item, checks against the oldest expectation
   initial begin
      int      stall_left;
      rsp_type want;
      stall_left = 0;
      rsp_stall = 1'b0;
      forever begin
         @(posedge clock);
         if (!reset && rsp_valid && !rsp_stall) begin
            if (pending_results.size() == 0) begin
               $error("result with nothing expected: sum_min %0d status %0d last %0d",
                      rsp_data.sum_min, rsp_data.status, rsp_data.last);
               fail_count++;
            end else begin
               want = pending_results.pop_front();
               if (rsp_data.sum_min !== want.sum_min) begin
                  $error("sum_min: expected %0d, got %0d", want.sum_min, rsp_data.sum_min);
                  fail_count++;
               end
               if (rsp_data.status !== want.status) begin
                  $error("status: expected %0d, got %0d", want.status, rsp_data.status);
                  fail_count++;
               end
               if (rsp_data.last !== want.last) begin
                  $error("last: expected %0d, got %0d", want.last, rsp_data.last);
                  fail_count++;
               end
            end
            stall_left = rsp_idle_on ? $urandom_range(0, 7) : 0;
         end
         if (stall_left > 0) begin
            rsp_stall <= 1'b1;
            stall_left--;
         end else begin
            rsp_stall <= 1'b0;
         end
      end
   end

   initial begin
      reset = 1'b1;
      req_valid = 1'b0;
      req_data = '0;
      repeat (12) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      test_empty_compute();
      test_value_extremes();
      test_neither_convex();
      test_convex_too_long();
      test_swapped_operands();
      test_random_runs(200);

      req_valid <= 1'b0;
      while (pending_results.size() != 0) @(posedge clock);
      repeat (16) @(posedge clock);
      if (fail_count == 0) begin
         $display("tb: success");
      end else begin
         $display("tb: failure");
      end
      $finish;
   end

endmodule
